// ===== hw/rtl/tcne_pkg.sv =====
`default_nettype none

package tcne_pkg;

	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;

	localparam int unsigned SKIP_W = 4;
	localparam logic [SKIP_W-1:0] SKIP_TABS_RESET = 4'd6;

	typedef enum logic [3:0] {
		MODE_WAIT    = 4'b0001,
		MODE_FIELD_A = 4'b0010,
		MODE_FIELD_B = 4'b0100,
		MODE_SKIP    = 4'b1000
	} mode_t;

	typedef struct packed {
		logic emit;
		logic field_index;
		logic is_error;
	} res_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcne_step.sv =====
`default_nettype none

module tcne_step #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  wire logic [7:0]                  in_byte,
	input  wire logic [tcne_pkg::SKIP_W-1:0] skip_tabs,
	input  wire tcne_pkg::mode_t             mode,
	input  wire logic [tcne_pkg::SKIP_W-1:0] tab_cnt,
	input  wire logic [VALUE_BITS-1:0]       acc,
	output tcne_pkg::mode_t                  mode_nxt,
	output logic [tcne_pkg::SKIP_W-1:0]      tab_cnt_nxt,
	output logic [VALUE_BITS-1:0]            acc_nxt,
	output logic [VALUE_BITS-1:0]            res_value,
	output tcne_pkg::res_ctl_t               res_ctl
);
	import tcne_pkg::*;

	logic                  is_tab;
	logic                  is_nl;
	logic                  is_digit;
	logic [3:0]            digit_raw;
	logic [SKIP_W-1:0]     tab_inc;
	logic [VALUE_BITS-1:0] acc_x10_d;

	assign is_tab    = (in_byte == CHAR_TAB);
	assign is_nl     = (in_byte == CHAR_NEWLINE);
	assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
	assign digit_raw = 4'(in_byte - CHAR_ZERO);
	assign tab_inc   = tab_cnt + SKIP_W'(1);

	// x10 as x8 + x2
	assign acc_x10_d = {acc[VALUE_BITS-4:0], 3'b000} + {acc[VALUE_BITS-2:0], 1'b0}
		+ VALUE_BITS'(digit_raw);

	always_comb begin
		mode_nxt    = mode;
		tab_cnt_nxt = tab_cnt;
		acc_nxt     = acc;
		res_value   = '0;
		res_ctl     = '0;
		case (mode)
			MODE_WAIT: begin
				if (is_tab) begin
					if (tab_inc >= skip_tabs) begin
						tab_cnt_nxt = '0;
						mode_nxt    = MODE_FIELD_A;
					end else begin
						tab_cnt_nxt = tab_inc;
					end
				end
			end
			MODE_FIELD_A, MODE_FIELD_B: begin
				res_ctl.field_index = (mode == MODE_FIELD_B);
				if (is_digit) begin
					acc_nxt = acc_x10_d;
				end else begin
					res_ctl.emit = 1'b1;
					acc_nxt      = '0;
					if (is_tab) begin
						res_value = acc;
						mode_nxt  = (mode == MODE_FIELD_A) ? MODE_FIELD_B : MODE_SKIP;
					end else begin
						res_ctl.is_error = 1'b1;
						mode_nxt         = MODE_SKIP;
					end
				end
			end
			MODE_SKIP: begin
				if (is_nl) begin
					mode_nxt = MODE_WAIT;
				end
			end
			default: begin
				mode_nxt = MODE_WAIT;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tsv_column_number_extractor.sv =====
// Path: an accepted byte is held in the input register; when the result
// register is free or being taken, the parse step loads any result beat.
// Throughput: one byte per cycle unless the output stalls; the combinational
// parse step (x10 add, mode update) is between input and result register.
// Reset (arst_n, async, active low): waiting for tabs, tab count and
// accumulator zero, skip_tabs 6, no beat held on either side.
`default_nettype none

module tsv_column_number_extractor #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tcne_pkg::SKIP_W-1:0]    cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     in_byte,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [VALUE_BITS-1:0]               value,
	output logic                                field_index,
	output logic                                is_error
);
	import tcne_pkg::*;

	logic [SKIP_W-1:0]     skip_q;
	logic [7:0]            byte_s1;
	logic                  valid_s1;
	logic                  step_en;
	mode_t                 mode_q;
	mode_t                 mode_nxt;
	logic [SKIP_W-1:0]     tab_cnt_q;
	logic [SKIP_W-1:0]     tab_cnt_nxt;
	logic [VALUE_BITS-1:0] acc_q;
	logic [VALUE_BITS-1:0] acc_nxt;
	logic [VALUE_BITS-1:0] res_value;
	res_ctl_t              res_ctl;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  field_index_q;
	logic                  is_error_q;

	assign step_en  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= SKIP_TABS_RESET;
		end else if (cfg_we) begin
			skip_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	tcne_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.in_byte     (byte_s1),
		.skip_tabs   (skip_q),
		.mode        (mode_q),
		.tab_cnt     (tab_cnt_q),
		.acc         (acc_q),
		.mode_nxt    (mode_nxt),
		.tab_cnt_nxt (tab_cnt_nxt),
		.acc_nxt     (acc_nxt),
		.res_value   (res_value),
		.res_ctl     (res_ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_WAIT;
			tab_cnt_q <= '0;
			acc_q     <= '0;
		end else if (step_en) begin
			mode_q    <= mode_nxt;
			tab_cnt_q <= tab_cnt_nxt;
			acc_q     <= acc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && res_ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res_ctl.emit) begin
			value_q       <= res_value;
			field_index_q <= res_ctl.field_index;
			is_error_q    <= res_ctl.is_error;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign field_index = field_index_q;
	assign is_error    = is_error_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tcne_checker.sv =====
`default_nettype none

module tcne_checker #(
	parameter int unsigned VALUE_BITS = 64
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [VALUE_BITS-1:0] value,
	input wire logic                  field_index,
	input wire logic                  is_error
);

	// set after a clean first-field beat, until the next result beat
	logic want_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_second_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			want_second_q <= !field_index && !is_error;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value)
			&& $stable(field_index) && $stable(is_error))
		else $error("result beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_error |-> value == '0)
		else $error("error beat with non-zero value");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && want_second_q |-> field_index)
		else $error("clean first field not followed by second field");

	// a fresh result beat must trace back to a byte taken at the input
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result beat with no byte taken");

endmodule

bind tsv_column_number_extractor tcne_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_tcne_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.value       (value),
	.field_index (field_index),
	.is_error    (is_error)
);

`default_nettype wire
